// ----- hw/rtl/priority_rule_packet_classifier_core_defines.svh -----
// ---------------------------------------------------------------------------
// priority rule classifier assertion macros
// shared assertion helpers for the classifier checker
// ---------------------------------------------------------------------------
`ifndef PRIORITY_RULE_PACKET_CLASSIFIER_CORE_DEFINES_SVH
`define PRIORITY_RULE_PACKET_CLASSIFIER_CORE_DEFINES_SVH

// generic clocked assertion with active-low reset
`define PRC_ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("classifier assertion failed");

// assertion on the block clock and reset
`define PRC_ASSERT(lbl, prop) `PRC_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

// ----- hw/rtl/prc_pkg.sv -----
// ---------------------------------------------------------------------------
// prc_pkg
// types, constants and match function of the priority rule classifier
// ---------------------------------------------------------------------------
package prc_pkg;

    localparam int RULE_SLOTS = 32;
    localparam int IDX_W      = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic       ACT_WRITE    = 1'b0;
    localparam logic       ACT_CLASSIFY = 1'b1;
    localparam logic [1:0] DIR_EITHER   = 2'd2;
    localparam logic [31:0] HIT_MAX     = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        action;
        logic [4:0]  rule_slot;
        logic        rule_enabled;
        logic [7:0]  rule_priority;
        logic [1:0]  direction;
        logic [7:0]  protocol;
        logic [15:0] port_low;
        logic [15:0] port_high;
        logic        address_check;
        logic [31:0] ipv4_address;
        logic [2:0]  rule_verdict;
    } t_item;

    typedef struct packed {
        logic [2:0]  verdict;
        logic        matched;
        logic [4:0]  matched_slot;
        logic [31:0] hit_total;
    } t_result;

    typedef struct packed {
        logic [7:0]  pri;
        logic [1:0]  dir;
        logic [7:0]  proto;
        logic [15:0] port_lo;
        logic [15:0] port_hi;
        logic        addr_chk;
        logic [31:0] addr;
        logic [2:0]  verd;
    } t_rule;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_SKIP,
        CMD_CLASSIFY
    } t_cmd_kind;

    // for a classify, rule carries the connection: dir, proto, port_lo, addr
    typedef struct packed {
        t_cmd_kind        kind;
        logic [IDX_W-1:0] slot;
        logic             en;
        t_rule            rule;
    } t_cmd;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_HIT_RD,
        BK_HIT_WR,
        BK_OUT
    } t_bk_state;

    function automatic logic rule_match(t_rule r, t_rule c);
        logic dir_ok;
        logic proto_ok;
        logic port_ok;
        logic addr_ok;
        dir_ok   = (r.dir == DIR_EITHER) || (r.dir == c.dir);
        proto_ok = (r.proto == 8'd0) || (r.proto == c.proto);
        if (r.port_lo == 16'd0) begin
            port_ok = 1'b1;
        end else if (r.port_hi != 16'd0) begin
            port_ok = (c.port_lo >= r.port_lo) && (c.port_lo <= r.port_hi);
        end else begin
            port_ok = (c.port_lo == r.port_lo);
        end
        addr_ok  = !r.addr_chk || (r.addr == c.addr);
        return dir_ok && proto_ok && port_ok && addr_ok;
    endfunction

endpackage

// ----- hw/rtl/prc_ifs.sv -----
// ---------------------------------------------------------------------------
// prc channel interfaces
// valid/ready channels for items, results and the config register
// ---------------------------------------------------------------------------
interface prc_item_if import prc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface prc_result_if import prc_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface prc_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/priority_rule_packet_classifier_core.sv -----
// ---------------------------------------------------------------------------
// priority_rule_packet_classifier_core
// rule table classifier: stores filter rules and picks the best match
// ---------------------------------------------------------------------------
// i_item carries one transaction per rule write or connection classify;
// o_result returns exactly one transaction per item, in order. i_cfg writes
// the default verdict and is always ready; write it only while idle.
// The front registers and sorts each item into a two-entry command queue, so
// new items are taken while the back is busy or its result waits.
// A write passes the back through its output state only. A classify scans
// the rule table one slot per cycle through its single read port, then
// drains, reads and writes the hit counter of the winner when a rule
// matches, and moves the result to the output register.
// Reset clears every rule's enable bit and hit-counter valid bit, the default
// verdict and all queues; the block is ready for items right after reset.
// When the receiver stalls, the result stays in the output register, the
// back waits and the queue fills; i_item.ready then falls.
// ---------------------------------------------------------------------------
module priority_rule_packet_classifier_core import prc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    prc_item_if.sink     i_item,
    prc_cfg_if.sink      i_cfg,
    prc_result_if.source o_result
);

    logic f_valid;
    t_cmd f_cmd;
    logic f_ready;
    logic q_valid;
    t_cmd q_cmd;
    logic q_ready;

    prc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .o_push_valid (f_valid),
        .o_push_cmd   (f_cmd),
        .i_push_ready (f_ready)
    );

    prc_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .i_push_cmd   (f_cmd),
        .o_push_ready (f_ready),
        .o_pop_valid  (q_valid),
        .o_pop_cmd    (q_cmd),
        .i_pop_ready  (q_ready)
    );

    prc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_ready (q_ready),
        .o_result    (o_result)
    );

endmodule

// ----- hw/rtl/prc_front.sv -----
// ---------------------------------------------------------------------------
// prc_front
// accepts input items, sorts them into commands and offers them to the queue
// ---------------------------------------------------------------------------
module prc_front import prc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prc_item_if.sink    i_item,
    output logic        o_push_valid,
    output t_cmd        o_push_cmd,
    input  logic        i_push_ready
);

    logic r_hold_valid;
    t_cmd r_hold;
    t_cmd n_hold;
    logic take;

    assign i_item.ready = !r_hold_valid || i_push_ready;
    assign take         = i_item.valid && i_item.ready;

    always_comb begin
        n_hold.slot          = IDX_W'(i_item.data.rule_slot);
        n_hold.en            = i_item.data.rule_enabled;
        n_hold.rule.pri      = i_item.data.rule_priority;
        n_hold.rule.dir      = i_item.data.direction;
        n_hold.rule.proto    = i_item.data.protocol;
        n_hold.rule.port_lo  = i_item.data.port_low;
        n_hold.rule.port_hi  = i_item.data.port_high;
        n_hold.rule.addr_chk = i_item.data.address_check;
        n_hold.rule.addr     = i_item.data.ipv4_address;
        n_hold.rule.verd     = i_item.data.rule_verdict;
        if (i_item.data.action == ACT_CLASSIFY) begin
            n_hold.kind = CMD_CLASSIFY;
        end else if (32'(i_item.data.rule_slot) < RULE_SLOTS) begin
            n_hold.kind = CMD_WRITE;
        end else begin
            // slot beyond the table still answers with a zero result
            n_hold.kind = CMD_SKIP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
        end else if (take) begin
            r_hold_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_hold_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_hold <= n_hold;
        end
    end

    assign o_push_valid = r_hold_valid;
    assign o_push_cmd   = r_hold;

endmodule

// ----- hw/rtl/prc_fifo.sv -----
// ---------------------------------------------------------------------------
// prc_fifo
// short command queue between the front and the back
// ---------------------------------------------------------------------------
module prc_fifo import prc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_cmd i_push_cmd,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_cmd o_pop_cmd,
    input  logic i_pop_ready
);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != FIFO_CW'(FIFO_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                            : r_wr_ptr + FIFO_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                            : r_rd_ptr + FIFO_AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + FIFO_CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - FIFO_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ----- hw/rtl/prc_back.sv -----
// ---------------------------------------------------------------------------
// prc_back
// rule table, slot-by-slot priority scan, hit counters and result register
// ---------------------------------------------------------------------------
module prc_back import prc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    prc_cfg_if.sink       i_cfg,
    input  logic          i_cmd_valid,
    input  t_cmd          i_cmd,
    output logic          o_cmd_ready,
    prc_result_if.source  o_result
);

    t_rule             rule_mem [RULE_SLOTS];
    logic [31:0]       hit_mem  [RULE_SLOTS];
    logic [RULE_SLOTS-1:0] r_rule_en;
    logic [RULE_SLOTS-1:0] r_hit_vld;

    t_bk_state         r_state;
    t_bk_state         n_state;
    logic [2:0]        r_default_verdict;
    t_cmd              r_cmd;
    logic [IDX_W-1:0]  r_idx;
    logic              r_eval_valid;
    logic [IDX_W-1:0]  r_eval_idx;
    t_rule             r_rd_rule;
    logic              r_rd_en;
    logic              r_found;
    logic [7:0]        r_best_pri;
    logic [2:0]        r_best_verd;
    logic [IDX_W-1:0]  r_best;
    logic [31:0]       r_hit_q;
    logic              r_hit_ok;
    t_result           r_res;
    logic              r_out_valid;
    t_result           r_out;

    logic              cand_hit;
    logic              n_found;
    logic              out_free;
    logic              pop;
    logic              do_write;
    logic [31:0]       hit_cur;
    logic [31:0]       hit_next;

    assign i_cfg.ready = 1'b1;
    assign out_free    = !r_out_valid || o_result.ready;
    assign pop         = i_cmd_valid && o_cmd_ready;
    assign do_write    = pop && (i_cmd.kind == CMD_WRITE);

    // later rule replaces the best only on strictly higher priority
    assign cand_hit = r_eval_valid && r_rd_en
                      && (!r_found || (r_rd_rule.pri > r_best_pri))
                      && rule_match(r_rd_rule, r_cmd.rule);
    assign n_found  = r_found || cand_hit;

    assign hit_cur  = r_hit_ok ? r_hit_q : 32'd0;
    assign hit_next = (hit_cur == HIT_MAX) ? hit_cur : hit_cur + 32'd1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = (i_cmd.kind == CMD_CLASSIFY) ? BK_SCAN : BK_OUT;
                end
            end
            BK_SCAN: begin
                if (r_idx == IDX_W'(RULE_SLOTS - 1)) begin
                    n_state = BK_DRAIN;
                end
            end
            BK_DRAIN:  n_state = n_found ? BK_HIT_RD : BK_OUT;
            BK_HIT_RD: n_state = BK_HIT_WR;
            BK_HIT_WR: n_state = BK_OUT;
            BK_OUT: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default:   n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        case (r_state)
            BK_IDLE: o_cmd_ready = 1'b1;
            default: o_cmd_ready = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= BK_IDLE;
            r_default_verdict <= 3'd0;
            r_rule_en         <= '0;
            r_hit_vld         <= '0;
            r_eval_valid      <= 1'b0;
            r_found           <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_default_verdict <= i_cfg.data;
            end
            if (do_write) begin
                r_rule_en[i_cmd.slot] <= i_cmd.en;
                r_hit_vld[i_cmd.slot] <= 1'b0;
            end
            if (r_state == BK_HIT_WR) begin
                r_hit_vld[r_best] <= 1'b1;
            end
            if (pop) begin
                r_eval_valid <= 1'b0;
                r_found      <= 1'b0;
            end else if (r_state == BK_SCAN) begin
                r_eval_valid <= 1'b1;
                r_found      <= n_found;
            end else if (r_state == BK_DRAIN) begin
                r_eval_valid <= 1'b0;
                r_found      <= n_found;
            end
            if ((r_state == BK_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // table and counter memories
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            rule_mem[i_cmd.slot] <= i_cmd.rule;
        end
        if (r_state == BK_SCAN) begin
            r_rd_rule <= rule_mem[r_idx];
        end
        if (r_state == BK_HIT_RD) begin
            r_hit_q <= hit_mem[r_best];
        end
        if (r_state == BK_HIT_WR) begin
            hit_mem[r_best] <= hit_next;
        end
    end

    // scan datapath
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_cmd;
            r_idx <= '0;
            r_res <= '0;
        end
        if (r_state == BK_SCAN) begin
            r_rd_en    <= r_rule_en[r_idx];
            r_eval_idx <= r_idx;
            r_idx      <= r_idx + IDX_W'(1);
        end
        if (cand_hit) begin
            r_best      <= r_eval_idx;
            r_best_pri  <= r_rd_rule.pri;
            r_best_verd <= r_rd_rule.verd;
        end
        if (r_state == BK_DRAIN && !n_found) begin
            r_res.verdict      <= r_default_verdict;
            r_res.matched      <= 1'b0;
            r_res.matched_slot <= 5'd0;
            r_res.hit_total    <= 32'd0;
        end
        if (r_state == BK_HIT_RD) begin
            r_hit_ok <= r_hit_vld[r_best];
        end
        if (r_state == BK_HIT_WR) begin
            r_res.verdict      <= r_best_verd;
            r_res.matched      <= 1'b1;
            r_res.matched_slot <= 5'(r_best);
            r_res.hit_total    <= hit_next;
        end
        if ((r_state == BK_OUT) && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

endmodule

// ----- hw/rtl/prc_checker.sv -----
// ---------------------------------------------------------------------------
// prc_checker
// port-level checks on the classifier result channel
// ---------------------------------------------------------------------------
`include "priority_rule_packet_classifier_core_defines.svh"

module prc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_verdict,
    input logic        i_matched,
    input logic [4:0]  i_matched_slot,
    input logic [31:0] i_hit_total
);

    logic [40:0] res_bits;
    logic        tail_zero;

    assign res_bits  = {i_verdict, i_matched, i_matched_slot, i_hit_total};
    assign tail_zero = (i_matched_slot == 5'd0) && (i_hit_total == 32'd0);

    // a waiting result keeps its contents
    `PRC_ASSERT(a_out_hold, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(res_bits)))

    // no winner means no slot and no count
    `PRC_ASSERT(a_unmatched_zero, (i_out_valid && !i_matched) |-> tail_zero)

    // a winner has been counted at least once
    `PRC_ASSERT(a_matched_counted, (i_out_valid && i_matched) |-> (i_hit_total != 32'd0))

endmodule

bind priority_rule_packet_classifier_core prc_checker u_prc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_verdict      (o_result.data.verdict),
    .i_matched      (o_result.data.matched),
    .i_matched_slot (o_result.data.matched_slot),
    .i_hit_total    (o_result.data.hit_total)
);
